// File: sv/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fern_pkg.sv
// fern point generator package: widths, map codes and affine coefficients
// no dependencies
package fern_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int COORD_WIDTH = 18;
  localparam int COEF_WIDTH  = FRAC_BITS + 2;
  localparam int SUM_WIDTH   = ((COORD_WIDTH > COEF_WIDTH) ? COORD_WIDTH : COEF_WIDTH) + 2;
  localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
  localparam int THR_WIDTH   = 16;
  localparam int WORD_WIDTH  = 16;
  localparam int OUT_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [THR_WIDTH-1:0] THR_STEM_RESET = 16'd1311;
  localparam logic [THR_WIDTH-1:0] THR_MAIN_RESET = 16'd56361;
  localparam logic [THR_WIDTH-1:0] THR_LEFT_RESET = 16'd60948;

  localparam logic [1:0] REG_STEM = 2'd0;
  localparam logic [1:0] REG_MAIN = 2'd1;
  localparam logic [1:0] REG_LEFT = 2'd2;

  localparam logic [1:0] MAP_STEM  = 2'd0;
  localparam logic [1:0] MAP_MAIN  = 2'd1;
  localparam logic [1:0] MAP_LEFT  = 2'd2;
  localparam logic [1:0] MAP_RIGHT = 2'd3;

  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t e;
    coef_t c;
    coef_t d;
    coef_t f;
  } map_coef_t;

  // nearest multiple of 2^-FRAC_BITS, ties away from zero
  localparam coef_t K_000 = coef_t'(0);
  localparam coef_t K_P250 = coef_t'(((250 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_N400 = coef_t'(-(((400 << FRAC_BITS) + 500) / 1000));
  localparam coef_t K_P950 = coef_t'(((950 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_P005 = coef_t'(((5 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_N002 = coef_t'(-(((2 << FRAC_BITS) + 500) / 1000));
  localparam coef_t K_N005 = coef_t'(-(((5 << FRAC_BITS) + 500) / 1000));
  localparam coef_t K_P930 = coef_t'(((930 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_P500 = coef_t'(((500 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_P035 = coef_t'(((35 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_N200 = coef_t'(-(((200 << FRAC_BITS) + 500) / 1000));
  localparam coef_t K_N090 = coef_t'(-(((90 << FRAC_BITS) + 500) / 1000));
  localparam coef_t K_P160 = coef_t'(((160 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_P040 = coef_t'(((40 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_P020 = coef_t'(((20 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_N040 = coef_t'(-(((40 << FRAC_BITS) + 500) / 1000));
  localparam coef_t K_P200 = coef_t'(((200 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_P083 = coef_t'(((83 << FRAC_BITS) + 500) / 1000);
  localparam coef_t K_P120 = coef_t'(((120 << FRAC_BITS) + 500) / 1000);

  // x' = a*x + b*y + e, y' = c*x + d*y + f
  function automatic map_coef_t map_coef(input logic [1:0] sel);
    map_coef_t m;
    case (sel)
      MAP_STEM:  m = '{a: K_000,  b: K_000,  e: K_000,  c: K_000,  d: K_P250, f: K_N400};
      MAP_MAIN:  m = '{a: K_P950, b: K_P005, e: K_N002, c: K_N005, d: K_P930, f: K_P500};
      MAP_LEFT:  m = '{a: K_P035, b: K_N200, e: K_N090, c: K_P160, d: K_P040, f: K_P020};
      MAP_RIGHT: m = '{a: K_N040, b: K_P200, e: K_P083, c: K_P160, d: K_P040, f: K_P120};
      default:   m = '{a: K_000,  b: K_000,  e: K_000,  c: K_000,  d: K_000,  f: K_000};
    endcase
    return m;
  endfunction

endpackage

// File: sv/fern_ifs_point_generator_unit.sv
// fern point generator top level: map select, affine update, saturation
// depends on fern_pkg and assert_macros.svh
//
//  channel | dir | handshake                      | payload
//  in_     | in  | in_tvalid / in_tready          | in_tdata: random_word
//  out_    | out | out_tvalid / out_tready        | out_tdata: new_x, new_y; out_tuser: map_used
//  cfg_    | in  | cfg_psel, cfg_penable, cfg_pwrite | cfg_paddr, cfg_pwdata, cfg_prdata
//
// one item per cycle unless the output stalls; a result is valid the cycle after its item is accepted
// the path is threshold compare, two constant-table multiply pairs, add and saturate
// synchronous active-low reset returns the point to the origin and thresholds to defaults
// a held result blocks new items only while out_tready is low
`include "assert_macros.svh"

module fern_ifs_point_generator_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [fern_pkg::WORD_WIDTH-1:0]         in_tdata,   // random_word
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [fern_pkg::OUT_DATA_WIDTH-1:0]     out_tdata,  // new_x, new_y, zero fill
  output logic [1:0]                              out_tuser,  // map_used
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [fern_pkg::CFG_ADDR_WIDTH-1:0]     cfg_paddr,
  input  logic [fern_pkg::CFG_DATA_WIDTH-1:0]     cfg_pwdata,
  output logic [fern_pkg::CFG_DATA_WIDTH-1:0]     cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int CW = fern_pkg::COORD_WIDTH;
  localparam int KW = fern_pkg::COEF_WIDTH;
  localparam int SW = fern_pkg::SUM_WIDTH;
  localparam int PW = fern_pkg::PROD_WIDTH;
  localparam int TW = fern_pkg::THR_WIDTH;

  logic [TW-1:0]            thr_stem_r, thr_main_r, thr_left_r;
  fern_pkg::coord_t         point_x_r, point_y_r;
  logic                     out_valid_r;
  fern_pkg::coord_t         out_x_r, out_y_r;
  logic [1:0]               out_map_r;

  logic                     cfg_wr;
  logic [1:0]               cfg_idx;
  logic                     in_acc;
  logic [1:0]               sel;
  fern_pkg::map_coef_t      mc;
  logic signed [PW-1:0]     p_ax, p_by, p_cx, p_dy;
  logic signed [PW-1:0]     s_ax, s_by, s_cx, s_dy;
  logic signed [SW-1:0]     sum_x, sum_y;
  fern_pkg::coord_t         sat_x, sat_y;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      fern_pkg::REG_STEM: cfg_prdata = {{(fern_pkg::CFG_DATA_WIDTH-TW){1'b0}}, thr_stem_r};
      fern_pkg::REG_MAIN: cfg_prdata = {{(fern_pkg::CFG_DATA_WIDTH-TW){1'b0}}, thr_main_r};
      fern_pkg::REG_LEFT: cfg_prdata = {{(fern_pkg::CFG_DATA_WIDTH-TW){1'b0}}, thr_left_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_stem_r <= fern_pkg::THR_STEM_RESET;
      thr_main_r <= fern_pkg::THR_MAIN_RESET;
      thr_left_r <= fern_pkg::THR_LEFT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fern_pkg::REG_STEM: thr_stem_r <= cfg_pwdata[TW-1:0];
        fern_pkg::REG_MAIN: thr_main_r <= cfg_pwdata[TW-1:0];
        fern_pkg::REG_LEFT: thr_left_r <= cfg_pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // map select, first threshold that holds wins
  always_comb begin
    if (in_tdata < thr_stem_r) begin
      sel = fern_pkg::MAP_STEM;
    end else if (in_tdata < thr_main_r) begin
      sel = fern_pkg::MAP_MAIN;
    end else if (in_tdata < thr_left_r) begin
      sel = fern_pkg::MAP_LEFT;
    end else begin
      sel = fern_pkg::MAP_RIGHT;
    end
  end

  assign mc = fern_pkg::map_coef(sel);

  // products truncated toward minus infinity
  assign p_ax = mc.a * point_x_r;
  assign p_by = mc.b * point_y_r;
  assign p_cx = mc.c * point_x_r;
  assign p_dy = mc.d * point_y_r;
  assign s_ax = p_ax >>> fern_pkg::FRAC_BITS;
  assign s_by = p_by >>> fern_pkg::FRAC_BITS;
  assign s_cx = p_cx >>> fern_pkg::FRAC_BITS;
  assign s_dy = p_dy >>> fern_pkg::FRAC_BITS;

  assign sum_x = s_ax[SW-1:0] + s_by[SW-1:0] + {{(SW-KW){mc.e[KW-1]}}, mc.e};
  assign sum_y = s_cx[SW-1:0] + s_dy[SW-1:0] + {{(SW-KW){mc.f[KW-1]}}, mc.f};

  // saturate to the coordinate range
  always_comb begin
    if ((&sum_x[SW-1:CW-1]) || !(|sum_x[SW-1:CW-1])) begin
      sat_x = sum_x[CW-1:0];
    end else begin
      sat_x = {sum_x[SW-1], {(CW-1){~sum_x[SW-1]}}};
    end
    if ((&sum_y[SW-1:CW-1]) || !(|sum_y[SW-1:CW-1])) begin
      sat_y = sum_y[CW-1:0];
    end else begin
      sat_y = {sum_y[SW-1], {(CW-1){~sum_y[SW-1]}}};
    end
  end

  // item handshake and result register
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_x_r   <= '0;
      point_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        point_x_r   <= sat_x;
        point_y_r   <= sat_y;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_x_r   <= sat_x;
      out_y_r   <= sat_y;
      out_map_r <= sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_map_r;
  assign out_tdata  = {{(fern_pkg::OUT_DATA_WIDTH-2*CW){1'b0}}, out_y_r, out_x_r};

  `ASSERT_NEXT(a_acc_gives_result, clk, rst_n, in_acc, out_tvalid, "accepted item without result")
  `ASSERT_NEXT(a_result_is_state, clk, rst_n, in_acc, (out_x_r == point_x_r) && (out_y_r == point_y_r), "result differs from stored point")
  `ASSERT_SAME(a_stall_blocks, clk, rst_n, out_tvalid && !out_tready, !in_tready, "item taken while result stalled")
  `ASSERT_SAME(a_stem_on_axis, clk, rst_n, out_tvalid && (out_tuser == fern_pkg::MAP_STEM), out_x_r == '0, "stem map left x off the axis")

endmodule

// File: tb/tb_fern_ifs_point_generator_unit.sv
`timescale 1ns / 1ps
// testbench for the fern point generator: random words go in on the stream input,
// a local predictor tracks the point and every result item is checked field by field
// depends on fern_pkg and fern_ifs_point_generator_unit
module tb_fern_ifs_point_generator_unit;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 200;
  localparam int PRESSURE_AT     = 500;
  localparam int PRESSURE_CYCLES = 300;
  localparam int DIRECTED_ROWS   = 35;
  localparam int CW              = fern_pkg::COORD_WIDTH;
  localparam int ODW             = fern_pkg::OUT_DATA_WIDTH;
  localparam logic [1:0] R_STEM  = fern_pkg::REG_STEM;
  localparam logic [1:0] R_MAIN  = fern_pkg::REG_MAIN;
  localparam logic [1:0] R_LEFT  = fern_pkg::REG_LEFT;
  localparam logic [1:0] M_STEM  = fern_pkg::MAP_STEM;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] value;
    logic [15:0] word;
    int          kx;
    int          ky;
    logic [1:0]  kmap;
  } stim_row_t;

  typedef struct {
    fern_pkg::coord_t x;
    fern_pkg::coord_t y;
    logic [1:0]       map;
  } fern_point_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [fern_pkg::WORD_WIDTH-1:0]     in_tdata = '0;      // random_word
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [ODW-1:0]                      out_tdata;          // new_x, new_y, zero fill
  logic [1:0]                          out_tuser;          // map_used
  logic                                cfg_psel = 1'b0;
  logic                                cfg_penable = 1'b0;
  logic                                cfg_pwrite = 1'b0;
  logic [fern_pkg::CFG_ADDR_WIDTH-1:0] cfg_paddr = '0;
  logic [fern_pkg::CFG_DATA_WIDTH-1:0] cfg_pwdata = '0;
  logic [fern_pkg::CFG_DATA_WIDTH-1:0] cfg_prdata;
  logic                                cfg_pready;

  fern_ifs_point_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #4 clk = ~clk;

  // affine maps in thousandths: a, b, e, c, d, f
  int map_milli [0:3][0:5] = '{
    '{  0,    0,   0,   0, 250, -400},
    '{950,    5,  -2,  -5, 930,  500},
    '{ 35, -200, -90, 160,  40,   20},
    '{-40,  200,  83, 160,  40,  120}
  };

  logic [15:0] thr_now [0:2] = '{fern_pkg::THR_STEM_RESET, fern_pkg::THR_MAIN_RESET,
                                 fern_pkg::THR_LEFT_RESET};
  fern_pkg::coord_t fern_x = '0;
  fern_pkg::coord_t fern_y = '0;
  fern_point_t pending_points [$];
  int          mismatches = 0;
  int          results_seen = 0;
  bit          send_calm = 1'b0;

  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{ROW_KNOWN, R_STEM, 32'd0, 16'd0,     0, -1638, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd1310,  0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd1311,  0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd56360, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd56361, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd60947, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd60948, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd65535, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'h5555,  0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'hAAAA,  0, 0, M_STEM},
    // thresholds out of order, with upper write bits set
    '{ROW_CFG,   R_STEM, 32'hFFFF_EA60, 16'd0, 0, 0, M_STEM},
    '{ROW_CFG,   R_MAIN, 32'h0000_0064, 16'd0, 0, 0, M_STEM},
    '{ROW_CFG,   R_LEFT, 32'h8000_7530, 16'd0, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd0,     0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd99,    0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd100,   0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd29999, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd30000, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd59999, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd60000, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd65535, 0, 0, M_STEM},
    // write to an index past the list is ignored
    '{ROW_CFG,   REG_SPARE, 32'h0000_0000, 16'd0, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd59999, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd60000, 0, 0, M_STEM},
    '{ROW_CFG,   R_STEM, 32'h0000_0000, 16'd0, 0, 0, M_STEM},
    '{ROW_CFG,   R_MAIN, 32'h0000_0000, 16'd0, 0, 0, M_STEM},
    '{ROW_CFG,   R_LEFT, 32'h0000_0000, 16'd0, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd0,     0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd65535, 0, 0, M_STEM},
    '{ROW_CFG,   R_STEM, 32'h0000_FFFF, 16'd0, 0, 0, M_STEM},
    '{ROW_CFG,   R_MAIN, 32'h0000_FFFF, 16'd0, 0, 0, M_STEM},
    '{ROW_CFG,   R_LEFT, 32'h0000_FFFF, 16'd0, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd65534, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd65535, 0, 0, M_STEM},
    '{ROW_ITEM,  R_STEM, 32'd0, 16'd0,     0, 0, M_STEM}
  };

  function automatic longint coef_fixed(int milli);
    longint mag;
    longint q;
    mag = (milli < 0) ? -longint'(milli) : longint'(milli);
    q = ((mag << fern_pkg::FRAC_BITS) + 500) / 1000;
    return (milli < 0) ? -q : q;
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -(longint'(1) << (CW - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // picks the map, applies it and moves the tracked point
  function automatic fern_point_t next_point(logic [15:0] word);
    logic [1:0]  sel;
    longint      x;
    longint      y;
    longint      nx;
    longint      ny;
    fern_point_t p;
    if (word < thr_now[R_STEM]) sel = fern_pkg::MAP_STEM;
    else if (word < thr_now[R_MAIN]) sel = fern_pkg::MAP_MAIN;
    else if (word < thr_now[R_LEFT]) sel = fern_pkg::MAP_LEFT;
    else sel = fern_pkg::MAP_RIGHT;
    x = fern_x;
    y = fern_y;
    nx = ((coef_fixed(map_milli[sel][0]) * x) >>> fern_pkg::FRAC_BITS)
       + ((coef_fixed(map_milli[sel][1]) * y) >>> fern_pkg::FRAC_BITS)
       + coef_fixed(map_milli[sel][2]);
    ny = ((coef_fixed(map_milli[sel][3]) * x) >>> fern_pkg::FRAC_BITS)
       + ((coef_fixed(map_milli[sel][4]) * y) >>> fern_pkg::FRAC_BITS)
       + coef_fixed(map_milli[sel][5]);
    fern_x = fern_pkg::coord_t'(clamp_coord(nx));
    fern_y = fern_pkg::coord_t'(clamp_coord(ny));
    p.x = fern_x;
    p.y = fern_y;
    p.map = sel;
    return p;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly uniform, some words at or beside a threshold, some at the ends
  function automatic logic [15:0] pick_word();
    int r;
    int t;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      t = thr_now[$urandom_range(0, 2)];
      t = t + int'($urandom_range(0, 2)) - 1;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      return t[15:0];
    end
    if (r == 1) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic offer_word(input logic [15:0] word, input bit use_known,
                            input fern_point_t known_pt);
    fern_point_t p;
    int          gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= word;
    p = next_point(word);
    pending_points.push_back(use_known ? known_pt : p);
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_threshold(logic [1:0] idx);
    logic [31:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    if (rd[15:0] !== thr_now[idx]) begin
      $display("%0t threshold %0d: expected %0d, got %0d", $time, idx, thr_now[idx], rd[15:0]);
      mismatches++;
    end
  endtask

  task automatic set_threshold(logic [1:0] idx, logic [31:0] value);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, value, rd);
    if (idx != REG_SPARE) begin
      thr_now[idx] = value[15:0];
      check_threshold(idx);
    end
  endtask

  // result side: random back-pressure, one long hold-off, field checks
  initial begin
    fern_point_t want;
    int          hold_left;
    int          stall_left;
    bit          recv_calm;
    bit          pressure_done;
    hold_left = 0;
    stall_left = 0;
    recv_calm = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        if (pending_points.size() == 0) begin
          $display("%0t unexpected item: expected none, got x %0d y %0d map %0d", $time,
                   fern_pkg::coord_t'(out_tdata[CW-1:0]),
                   fern_pkg::coord_t'(out_tdata[2*CW-1:CW]), out_tuser);
          mismatches++;
        end else begin
          want = pending_points.pop_front();
          if (out_tdata[CW-1:0] !== want.x) begin
            $display("%0t new_x: expected %0d, got %0d", $time, want.x,
                     fern_pkg::coord_t'(out_tdata[CW-1:0]));
            mismatches++;
          end
          if (out_tdata[2*CW-1:CW] !== want.y) begin
            $display("%0t new_y: expected %0d, got %0d", $time, want.y,
                     fern_pkg::coord_t'(out_tdata[2*CW-1:CW]));
            mismatches++;
          end
          if (out_tdata[ODW-1:2*CW] !== '0) begin
            $display("%0t fill bits: expected 0, got %h", $time, out_tdata[ODW-1:2*CW]);
            mismatches++;
          end
          if (out_tuser !== want.map) begin
            $display("%0t map_used: expected %0d, got %0d", $time, want.map, out_tuser);
            mismatches++;
          end
        end
      end
      @(negedge clk);
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        hold_left = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap(recv_calm);
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    fern_point_t known;
    logic [15:0] tset [0:2];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 3; i++) check_threshold(i[1:0]);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          wait_drained();
          set_threshold(directed_rows[i].idx, directed_rows[i].value);
        end
        ROW_KNOWN: begin
          known.x = fern_pkg::coord_t'(directed_rows[i].kx);
          known.y = fern_pkg::coord_t'(directed_rows[i].ky);
          known.map = directed_rows[i].kmap;
          offer_word(directed_rows[i].word, 1'b1, known);
        end
        default: begin
          offer_word(directed_rows[i].word, 1'b0, known);
        end
      endcase
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int i = 0; i < 3; i++) tset[i] = 16'($urandom_range(0, 65535));
      case (phase)
        0, 7: tset = '{fern_pkg::THR_STEM_RESET, fern_pkg::THR_MAIN_RESET,
                       fern_pkg::THR_LEFT_RESET};
        1, 5: tset.sort();
        2: tset = '{16'h0000, 16'h0000, 16'h0000};
        4: tset = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        6: begin
          tset[0] = 16'h0000;
          tset[1] = 16'hFFFF;
        end
        default: ;
      endcase
      wait_drained();
      for (int i = 0; i < 3; i++) set_threshold(i[1:0], {16'($urandom), tset[i]});
      repeat (PHASE_ITEMS) offer_word(pick_word(), 1'b0, known);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
